[rtl/core/gift128_block_cipher_core_assert.svh]
// ----------------------------------------------------------------------------
// GIFT-128 core assertion macros
// Shared property forms for the core's checkers.
// ----------------------------------------------------------------------------
`ifndef GIFT128_BLOCK_CIPHER_CORE_ASSERT_SVH
`define GIFT128_BLOCK_CIPHER_CORE_ASSERT_SVH

// same-cycle implication
`define GIFT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GIFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/gift_pkg.sv]
// ----------------------------------------------------------------------------
// GIFT-128 package
// Round functions, key schedule steps and control types for the core.
// ----------------------------------------------------------------------------
package gift_pkg;

  localparam int unsigned ROUNDS = 40;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned RC_W   = 6;

  typedef logic [3:0] nib_t;

  localparam nib_t SBOX_FWD [16] = '{
    4'h1, 4'hA, 4'h4, 4'hC, 4'h6, 4'hF, 4'h3, 4'h9,
    4'h2, 4'hD, 4'hB, 4'h7, 4'h5, 4'h0, 4'h8, 4'hE
  };

  localparam nib_t SBOX_INV [16] = '{
    4'hD, 4'h0, 4'h8, 4'h6, 4'h2, 4'hC, 4'h4, 4'hB,
    4'hE, 4'h7, 4'h1, 4'hA, 4'h3, 4'h9, 4'hF, 4'h5
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN
  } st_e;

  typedef struct packed {
    logic load;
    logic fwd;
    logic inv;
  } key_ctl_t;

  typedef struct packed {
    logic [31:0]     u;
    logic [31:0]     v;
    logic [RC_W-1:0] rc;
  } rk_t;

  function automatic logic [127:0] sub_cells(input logic [127:0] s, input logic dec);
    logic [127:0] t;
    t = '0;
    for (int n = 0; n < 32; n++) begin
      t[4*n +: 4] = dec ? SBOX_INV[s[4*n +: 4]] : SBOX_FWD[s[4*n +: 4]];
    end
    return t;
  endfunction

  function automatic logic [6:0] perm_pos(input int unsigned i);
    int unsigned a;
    int unsigned b;
    a = i % 4;
    b = (i % 16) / 4;
    return 7'(4 * (i / 16) + 32 * ((3 * b + a) % 4) + a);
  endfunction

  function automatic logic [127:0] perm_fwd(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int unsigned i = 0; i < 128; i++) begin
      t[perm_pos(i)] = s[i];
    end
    return t;
  endfunction

  function automatic logic [127:0] perm_rev(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int unsigned i = 0; i < 128; i++) begin
      t[i] = s[perm_pos(i)];
    end
    return t;
  endfunction

  function automatic logic [127:0] add_rk(input logic [127:0] s, input rk_t rk);
    logic [127:0] t;
    t = s;
    for (int i = 0; i < 32; i++) begin
      t[4*i+2] = s[4*i+2] ^ rk.u[i];
      t[4*i+1] = s[4*i+1] ^ rk.v[i];
    end
    for (int i = 0; i < RC_W; i++) begin
      t[4*i+3] = s[4*i+3] ^ rk.rc[i];
    end
    t[127] = ~s[127];
    return t;
  endfunction

  function automatic logic [127:0] key_fwd(input logic [127:0] k);
    logic [15:0] k0;
    logic [15:0] k1;
    k0 = k[15:0];
    k1 = k[31:16];
    return {k1[1:0], k1[15:2], k0[11:0], k0[15:12], k[127:96], k[95:64], k[63:32]};
  endfunction

  function automatic logic [127:0] key_inv(input logic [127:0] k);
    logic [15:0] n7;
    logic [15:0] n6;
    n7 = k[127:112];
    n6 = k[111:96];
    return {k[95:64], k[63:32], k[31:0], n7[13:0], n7[15:14], n6[3:0], n6[15:4]};
  endfunction

  function automatic logic [RC_W-1:0] lfsr_fwd(input logic [RC_W-1:0] c);
    return {c[4:0], c[5] ^ c[4] ^ 1'b1};
  endfunction

  function automatic logic [RC_W-1:0] lfsr_inv(input logic [RC_W-1:0] c);
    return {c[0] ^ c[5] ^ 1'b1, c[5:1]};
  endfunction

endpackage

[rtl/core/gift_round.sv]
// ----------------------------------------------------------------------------
// GIFT-128 round unit
// Cipher state register with the encrypt and decrypt rounds, selected by dec_i.
// ----------------------------------------------------------------------------
module gift_round import gift_pkg::*; (
  input  logic         clk_i,
  input  logic         load_i,
  input  logic [127:0] blk_i,
  input  logic         step_i,
  input  logic         dec_i,
  input  rk_t          rk_i,
  output logic [127:0] state_o
);

  logic [127:0] state_q;
  logic [127:0] state_d;
  logic [127:0] enc_nx;
  logic [127:0] dec_nx;

  assign enc_nx = add_rk(perm_fwd(sub_cells(state_q, 1'b0)), rk_i);
  assign dec_nx = sub_cells(perm_rev(add_rk(state_q, rk_i)), 1'b1);

  always_comb begin
    state_d = state_q;
    if (load_i) begin
      state_d = blk_i;
    end else if (step_i) begin
      state_d = dec_i ? dec_nx : enc_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign state_o = state_q;

endmodule

[rtl/core/gift_key.sv]
// ----------------------------------------------------------------------------
// GIFT-128 key schedule
// Key state and round constant, stepped forward or backward per round.
// ----------------------------------------------------------------------------
module gift_key import gift_pkg::*; (
  input  logic         clk_i,
  input  key_ctl_t     ctl_i,
  input  logic [127:0] key_i,
  output rk_t          rk_o
);

  logic [127:0]    key_q;
  logic [127:0]    key_d;
  logic [RC_W-1:0] rc_q;
  logic [RC_W-1:0] rc_d;
  logic [127:0]    key_prev;
  logic [RC_W-1:0] rc_next;

  assign key_prev = key_inv(key_q);
  assign rc_next  = lfsr_fwd(rc_q);

  always_comb begin
    key_d = key_q;
    rc_d  = rc_q;
    if (ctl_i.load) begin
      key_d = key_i;
      rc_d  = '0;
    end else if (ctl_i.fwd) begin
      key_d = key_fwd(key_q);
      rc_d  = rc_next;
    end else if (ctl_i.inv) begin
      key_d = key_prev;
      rc_d  = lfsr_inv(rc_q);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rc_q  <= rc_d;
  end

  always_comb begin
    if (ctl_i.inv) begin
      rk_o.u  = key_prev[95:64];
      rk_o.v  = key_prev[31:0];
      rk_o.rc = rc_q;
    end else begin
      rk_o.u  = key_q[95:64];
      rk_o.v  = key_q[31:0];
      rk_o.rc = rc_next;
    end
  end

endmodule

[rtl/core/gift128_block_cipher_core.sv]
// ----------------------------------------------------------------------------
// GIFT-128 block cipher core
// done_o follows the last round; decrypt first steps the key ahead (ST_PREP).
// A new request is taken only in ST_IDLE; the rounds never stall.
// rst_ni clears the FSM and key registers to zero; busy is low out of reset.
// ----------------------------------------------------------------------------
module gift128_block_cipher_core import gift_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  output logic        done_o,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);

  localparam logic       CFG_KEY_HIGH = 1'b0;
  localparam logic       CFG_KEY_LOW  = 1'b1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROUNDS - 1);

  logic [63:0]      key_high_q;
  logic [63:0]      key_low_q;
  st_e              st_q;
  st_e              st_d;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;
  logic             op_q;
  logic             op_d;
  logic             done_q;
  logic             done_d;
  logic             accept;
  logic             step;
  key_ctl_t         key_ctl;
  rk_t              rk;
  logic [127:0]     state;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        CFG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign accept = start && (st_q == ST_IDLE);

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    done_d  = 1'b0;
    step    = 1'b0;
    key_ctl = '0;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          key_ctl.load = 1'b1;
          op_d         = op_i;
          cnt_d        = '0;
          st_d         = op_i ? ST_PREP : ST_RUN;
        end
      end
      ST_PREP: begin
        key_ctl.fwd = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          cnt_d = '0;
          st_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        step        = 1'b1;
        key_ctl.fwd = !op_q;
        key_ctl.inv = op_q;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          cnt_d  = '0;
          done_d = 1'b1;
          st_d   = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= '0;
      op_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
      done_q <= done_d;
    end
  end

  gift_key u_key (
    .clk_i (clk_i),
    .ctl_i (key_ctl),
    .key_i ({key_high_q, key_low_q}),
    .rk_o  (rk)
  );

  gift_round u_round (
    .clk_i   (clk_i),
    .load_i  (accept),
    .blk_i   ({block_high_i, block_low_i}),
    .step_i  (step),
    .dec_i   (op_q),
    .rk_i    (rk),
    .state_o (state)
  );

  assign busy          = (st_q != ST_IDLE);
  assign done_o        = done_q;
  assign result_high_o = state[127:64];
  assign result_low_o  = state[63:0];

endmodule

[rtl/core/gift_chk.sv]
// ----------------------------------------------------------------------------
// GIFT-128 core checker
// Port-level handshake checks, bound to the core.
// ----------------------------------------------------------------------------
`include "gift128_block_cipher_core_assert.svh"

module gift_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_i
);

  `GIFT_ASSERT_NEXT(a_req_busy, start && !busy, busy, "request did not raise busy")
  `GIFT_ASSERT_SAME(a_done_idle, done_i, !busy, "busy during done")
  `GIFT_ASSERT_NEXT(a_done_pulse, done_i, !done_i, "done longer than one cycle")
  `GIFT_ASSERT_SAME(a_done_after_busy, done_i, $past(busy), "done without prior busy")
  `GIFT_ASSERT_SAME(a_busy_end, $fell(busy), done_i, "busy dropped without done")

endmodule

bind gift128_block_cipher_core gift_chk u_gift_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_i (done_o)
);
